/* rtl/smts_pkg.sv */
`timescale 1ns / 1ps
// Package for the SMBus master transfer sequencer.
// Holds status codes, control actions, register indexes and stream layouts; no dependencies.

package smts_pkg;

  // Upper bounds applied to the byte counts when a transfer starts.
  localparam int unsigned MAX_SEND    = 16;
  localparam int unsigned MAX_RECEIVE = 3;
  // Largest value the 5-bit send counter can hold after the start clamp.
  localparam int unsigned SEND_CAP    = (MAX_SEND > 31) ? 31 : MAX_SEND;

  // Slave addresses that select a receive slot.
  localparam logic [7:0] ACC_ADDRESS   = 8'h98;
  localparam logic [7:0] THERM_ADDRESS = 8'h91;
  localparam logic [7:0] READ_BIT      = 8'h01;
  localparam logic [1:0] ACC_SLOTS     = 2'd3;
  localparam logic [1:0] THERM_SLOTS   = 2'd2;

  // Bus status codes.
  localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_REP_START   = 8'h10;
  localparam logic [7:0] ST_ADDR_ACK    = 8'h18;
  localparam logic [7:0] ST_ADDR_NACK   = 8'h20;
  localparam logic [7:0] ST_DATA_ACK    = 8'h28;
  localparam logic [7:0] ST_DATA_NACK   = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_RD_ADDR_ACK = 8'h40;
  localparam logic [7:0] ST_RD_ADDR_NAK = 8'h48;
  localparam logic [7:0] ST_RD_DATA_ACK = 8'h50;
  localparam logic [7:0] ST_RD_DATA_NAK = 8'h58;

  // Input item kinds.
  localparam logic OP_START  = 1'b0;
  localparam logic OP_STATUS = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_ADDRESS   = 2'd0;
  localparam logic [1:0] REG_SEND_CNT  = 2'd1;
  localparam logic [1:0] REG_RECV_CNT  = 2'd2;
  localparam logic [1:0] REG_REP_START = 2'd3;

  // Flag actions for START and STOP.
  typedef enum logic [1:0] {
    CTL_KEEP  = 2'd0,
    CTL_CLEAR = 2'd1,
    CTL_SET   = 2'd2
  } ctl_t;

  // Receive slot selector.
  typedef enum logic [1:0] {
    TGT_NONE  = 2'd0,
    TGT_ACC   = 2'd1,
    TGT_THERM = 2'd2
  } target_t;

  // Result fields apart from the slot selector, highest bit first.
  typedef struct packed {
    logic       busy_res;
    logic [7:0] store_byte;
    logic [1:0] store_index;
    logic       send_advance;
    logic       ack_clear;
    ctl_t       stop_control;
    ctl_t       start_control;
    logic [7:0] transmit_byte;
    logic       transmit_valid;
  } result_t;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;

endpackage

/* rtl/smbus_master_transfer_sequencer.sv */
`timescale 1ns / 1ps
// SMBus master transfer sequencer: turns start requests and bus status codes into bus actions.
// Depends on smts_pkg for codes, control actions and the result layout.

// A transfer begins with a start item (in_tuser 0), which loads the byte counts from the
// configuration registers. Every item, whether a start or a bus status item (in_tuser 1),
// yields exactly one result. The result tells the bus interface what byte to load, how to
// drive START and STOP, and where a received byte belongs. The block takes one item per clock
// cycle while results are taken. Each accepted item is held in an input register and then
// decoded into the output register, so each result passes through both registers.
// While a result waits on out_tready, the input register holds one more item. After that,
// in_tready stays low until the result is taken. Configuration writes are taken at any time
// (cfg_ready is always high), but they should only be made while no item is in flight.
module smbus_master_transfer_sequencer
  import smts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  // Input channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata: status_code[7:0], received_byte[15:8], next_send_byte[23:16]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: opcode[0]
  input  logic                  in_tuser,
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: transmit_valid[0], transmit_byte[8:1], start_control[10:9],
  // stop_control[12:11], ack_clear[13], send_advance[14], store_index[16:15],
  // store_byte[24:17], busy_res[25], zeros[31:26]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: store_target[1:0]
  output logic [1:0]            out_tuser
);

  // Configuration registers.
  logic [7:0] address_byte_r;
  logic [4:0] send_count_r;
  logic [1:0] receive_count_r;
  logic       rep_start_read_r;

  // Transfer state.
  logic [4:0] bytes_to_send_r, bytes_to_send_nxt;
  logic [1:0] bytes_to_recv_r, bytes_to_recv_nxt;
  logic       busy_r, busy_nxt;

  // Input register.
  logic                 in_valid_r;
  logic [IN_DATA_W-1:0] in_data_r;
  logic                 in_user_r;

  // Output register.
  logic      out_valid_r;
  result_t   res_r, res_nxt;
  target_t   target_r, target_nxt;

  logic       proc_fire;
  logic [7:0] code, rx_byte, tx_byte;
  logic [4:0] send_clamp;
  logic [1:0] recv_clamp;

  assign cfg_ready = 1'b1;

  assign proc_fire = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_fire;

  assign code    = in_data_r[7:0];
  assign rx_byte = in_data_r[15:8];
  assign tx_byte = in_data_r[23:16];

  assign send_clamp = ({4'b0, send_count_r} > 9'(MAX_SEND)) ? 5'(MAX_SEND) : send_count_r;
  assign recv_clamp = ({2'b0, receive_count_r} > 4'(MAX_RECEIVE)) ?
                      2'(MAX_RECEIVE) : receive_count_r;

  always_comb begin
    res_nxt           = '0;
    res_nxt.start_control = CTL_KEEP;
    res_nxt.stop_control  = CTL_KEEP;
    target_nxt        = TGT_NONE;
    bytes_to_send_nxt = bytes_to_send_r;
    bytes_to_recv_nxt = bytes_to_recv_r;
    busy_nxt          = busy_r;

    if (in_user_r == OP_START) begin
      // A start request during a transfer is dropped.
      if (!busy_r) begin
        bytes_to_send_nxt     = send_clamp;
        bytes_to_recv_nxt     = recv_clamp;
        busy_nxt              = 1'b1;
        res_nxt.start_control = CTL_SET;
        res_nxt.stop_control  = CTL_CLEAR;
      end
    end else begin
      unique case (code)
        ST_START: begin
          res_nxt.transmit_valid = 1'b1;
          res_nxt.transmit_byte  = address_byte_r;
          res_nxt.start_control  = CTL_CLEAR;
        end
        ST_REP_START: begin
          res_nxt.transmit_valid = 1'b1;
          res_nxt.transmit_byte  = address_byte_r | READ_BIT;
          res_nxt.start_control  = CTL_CLEAR;
        end
        ST_ADDR_ACK, ST_DATA_ACK: begin
          if (bytes_to_send_r != 5'd0) begin
            res_nxt.transmit_valid = 1'b1;
            res_nxt.transmit_byte  = tx_byte;
            res_nxt.send_advance   = 1'b1;
            bytes_to_send_nxt      = bytes_to_send_r - 5'd1;
            if (code == ST_ADDR_ACK) begin
              res_nxt.start_control = CTL_CLEAR;
            end
          end else if (rep_start_read_r) begin
            // Writes are done; turn the bus around for the read phase.
            res_nxt.stop_control  = CTL_CLEAR;
            res_nxt.start_control = CTL_SET;
          end else begin
            res_nxt.stop_control = CTL_SET;
            busy_nxt             = 1'b0;
          end
        end
        ST_ADDR_NACK, ST_RD_ADDR_NAK: begin
          res_nxt.start_control = CTL_SET;
          res_nxt.stop_control  = CTL_SET;
        end
        ST_DATA_NACK: begin
          res_nxt.start_control = CTL_SET;
        end
        ST_ARB_LOST, ST_RD_DATA_NAK: begin
          res_nxt.stop_control = CTL_SET;
        end
        ST_RD_ADDR_ACK: begin
          res_nxt.start_control = CTL_CLEAR;
        end
        ST_RD_DATA_ACK: begin
          if (bytes_to_recv_r != 2'd0) begin
            if (address_byte_r == ACC_ADDRESS) begin
              target_nxt          = TGT_ACC;
              res_nxt.store_index = ACC_SLOTS - bytes_to_recv_r;
              res_nxt.store_byte  = rx_byte;
            end else if (address_byte_r == THERM_ADDRESS && bytes_to_recv_r <= THERM_SLOTS) begin
              target_nxt          = TGT_THERM;
              res_nxt.store_index = THERM_SLOTS - bytes_to_recv_r;
              res_nxt.store_byte  = rx_byte;
            end
            bytes_to_recv_nxt = bytes_to_recv_r - 2'd1;
          end else begin
            res_nxt.ack_clear    = 1'b1;
            res_nxt.stop_control = CTL_CLEAR;
            busy_nxt             = 1'b0;
          end
        end
        default: begin
          // Bus errors and unlisted codes leave everything as it is.
        end
      endcase
    end

    res_nxt.busy_res = busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_byte_r   <= '0;
      send_count_r     <= '0;
      receive_count_r  <= '0;
      rep_start_read_r <= 1'b0;
      bytes_to_send_r  <= '0;
      bytes_to_recv_r  <= '0;
      busy_r           <= 1'b0;
      in_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ADDRESS:   address_byte_r   <= cfg_data;
          REG_SEND_CNT:  send_count_r     <= cfg_data[4:0];
          REG_RECV_CNT:  receive_count_r  <= cfg_data[1:0];
          REG_REP_START: rep_start_read_r <= cfg_data[0];
          default: ;
        endcase
      end

      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end

      if (proc_fire) begin
        bytes_to_send_r <= bytes_to_send_nxt;
        bytes_to_recv_r <= bytes_to_recv_nxt;
        busy_r          <= busy_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_user_r <= in_tuser;
    end
    if (proc_fire) begin
      res_r    <= res_nxt;
      target_r <= target_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_r};
  assign out_tuser  = target_r;

`ifndef SYNTHESIS
  // A transfer may only end on a decoded status item.
  a_busy_falls_on_item: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) && $past(rst_n) |-> $past(proc_fire))
    else $error("busy dropped without a decoded item");

  // The reported busy flag matches the state left by the same item.
  a_busy_res_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $past(proc_fire) && $past(rst_n) |-> res_r.busy_res == busy_r)
    else $error("busy_res disagrees with the transfer state");

  // The send counter never exceeds the clamp applied at start.
  a_send_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_to_send_r <= 5'(SEND_CAP))
    else $error("send counter above its limit");
`endif

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for smbus_master_transfer_sequencer.
// Depends on smts_pkg and the block RTL; predicts every result in-line and checks each transfer.

module tb;
  import smts_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int ITEM_TARGET   = 2050;
  localparam int MAX_REPORTS   = 100;
  localparam logic [7:0] KNOWN_CODES [12] = '{
    ST_BUS_ERROR, ST_START, ST_REP_START, ST_ADDR_ACK, ST_ADDR_NACK, ST_DATA_ACK,
    ST_DATA_NACK, ST_ARB_LOST, ST_RD_ADDR_ACK, ST_RD_ADDR_NAK, ST_RD_DATA_ACK,
    ST_RD_DATA_NAK
  };

  typedef struct packed {
    target_t tgt;
    result_t res;
  } bus_action_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [7:0]            cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  // in_tdata: status_code[7:0], received_byte[15:8], next_send_byte[23:16]
  logic [IN_DATA_W-1:0]  in_tdata;
  // in_tuser: opcode[0]
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata: transmit_valid[0], transmit_byte[8:1], start_control[10:9],
  // stop_control[12:11], ack_clear[13], send_advance[14], store_index[16:15],
  // store_byte[24:17], busy_res[25], zeros[31:26]
  logic [OUT_DATA_W-1:0] out_tdata;
  // out_tuser: store_target[1:0]
  logic [1:0]            out_tuser;

  smbus_master_transfer_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Configuration and transfer state as the block should hold them.
  logic [7:0]  slave_addr;
  logic [4:0]  send_cfg;
  logic [1:0]  recv_cfg;
  logic        rep_start_cfg;
  logic [4:0]  send_left;
  logic [1:0]  recv_left;
  logic        xfer_busy;

  bus_action_t pending_actions [$];
  bus_action_t want;
  result_t     got;
  int          mismatches    = 0;
  int          items_sent    = 0;
  int          results_seen  = 0;
  int          configs_used  = 0;
  int          transfers_run = 0;
  int          cycle_count   = 0;
  int          hold_cnt      = 0;
  int          stall_pick;
  logic        steady        = 1'b0;

  function automatic bus_action_t predict_bus_action(input logic op, input logic [7:0] code,
                                                     input logic [7:0] rx,
                                                     input logic [7:0] tx);
    bus_action_t a;
    a = '0;
    if (op == OP_START) begin
      if (!xfer_busy) begin
        send_left = (send_cfg > MAX_SEND) ? 5'(MAX_SEND) : send_cfg;
        recv_left = (recv_cfg > MAX_RECEIVE) ? 2'(MAX_RECEIVE) : recv_cfg;
        xfer_busy = 1'b1;
        a.res.start_control = CTL_SET;
        a.res.stop_control  = CTL_CLEAR;
      end
    end else begin
      case (code)
        ST_START: begin
          a.res.transmit_valid = 1'b1;
          a.res.transmit_byte  = slave_addr;
          a.res.start_control  = CTL_CLEAR;
        end
        ST_REP_START: begin
          a.res.transmit_valid = 1'b1;
          a.res.transmit_byte  = slave_addr | READ_BIT;
          a.res.start_control  = CTL_CLEAR;
        end
        ST_ADDR_ACK, ST_DATA_ACK: begin
          if (send_left != 0) begin
            a.res.transmit_valid = 1'b1;
            a.res.transmit_byte  = tx;
            a.res.send_advance   = 1'b1;
            send_left            = send_left - 5'd1;
            if (code == ST_ADDR_ACK) a.res.start_control = CTL_CLEAR;
          end else if (rep_start_cfg) begin
            // Writes are done: turn the bus around for the read phase.
            a.res.stop_control  = CTL_CLEAR;
            a.res.start_control = CTL_SET;
          end else begin
            a.res.stop_control = CTL_SET;
            xfer_busy          = 1'b0;
          end
        end
        ST_ADDR_NACK, ST_RD_ADDR_NAK: begin
          a.res.start_control = CTL_SET;
          a.res.stop_control  = CTL_SET;
        end
        ST_DATA_NACK:                 a.res.start_control = CTL_SET;
        ST_ARB_LOST, ST_RD_DATA_NAK:  a.res.stop_control  = CTL_SET;
        ST_RD_ADDR_ACK:               a.res.start_control = CTL_CLEAR;
        ST_RD_DATA_ACK: begin
          if (recv_left != 0) begin
            // A thermometer byte with three still to come has no slot and is dropped.
            if (slave_addr == ACC_ADDRESS && recv_left <= ACC_SLOTS) begin
              a.tgt             = TGT_ACC;
              a.res.store_index = ACC_SLOTS - recv_left;
              a.res.store_byte  = rx;
            end else if (slave_addr == THERM_ADDRESS && recv_left <= THERM_SLOTS) begin
              a.tgt             = TGT_THERM;
              a.res.store_index = THERM_SLOTS - recv_left;
              a.res.store_byte  = rx;
            end
            recv_left = recv_left - 2'd1;
          end else begin
            a.res.ack_clear    = 1'b1;
            a.res.stop_control = CTL_CLEAR;
            xfer_busy          = 1'b0;
          end
        end
        default: ;
      endcase
    end
    a.res.busy_res = xfer_busy;
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic report_field(input string name, input logic [7:0] expected_v,
                              input logic [7:0] actual_v);
    if (expected_v !== actual_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, expected_v,
                 actual_v);
    end
  endtask

  // Result checker: compares each accepted transfer with the oldest prediction.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
      $display("smbus_master_transfer_sequencer test failed");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none, actual tdata %h tuser %h",
                   $time, out_tdata, out_tuser);
      end else begin
        want = pending_actions.pop_front();
        got  = out_tdata[25:0];
        report_field("transmit_valid", 8'(want.res.transmit_valid), 8'(got.transmit_valid));
        report_field("transmit_byte", want.res.transmit_byte, got.transmit_byte);
        report_field("start_control", 8'(want.res.start_control), 8'(got.start_control));
        report_field("stop_control", 8'(want.res.stop_control), 8'(got.stop_control));
        report_field("ack_clear", 8'(want.res.ack_clear), 8'(got.ack_clear));
        report_field("send_advance", 8'(want.res.send_advance), 8'(got.send_advance));
        report_field("store_target", 8'(want.tgt), 8'(out_tuser));
        report_field("store_index", 8'(want.res.store_index), 8'(got.store_index));
        report_field("store_byte", want.res.store_byte, got.store_byte);
        report_field("busy_res", 8'(want.res.busy_res), 8'(got.busy_res));
        report_field("tdata padding", 8'h00, 8'(out_tdata[31:26]));
      end
    end
  end

  // Result-side back-pressure: mostly ready, short stalls, now and then a long one.
  always @(negedge clk) begin
    if (steady) begin
      out_tready <= 1'b1;
      hold_cnt   <= 0;
    end else if (hold_cnt != 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 70) begin
        out_tready <= 1'b1;
      end else if (stall_pick < 96) begin
        out_tready <= 1'b0;
        hold_cnt   <= $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        hold_cnt   <= $urandom_range(8, 30);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with in_tvalid possibly still high.
  task automatic send_item(input logic op, input logic [7:0] code, input logic [7:0] rx,
                           input logic [7:0] tx);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {tx, rx, code};
    do @(posedge clk); while (!in_tready);
    pending_actions.push_back(predict_bus_action(op, code, rx, tx));
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_status(input logic [7:0] code, input logic [7:0] rx,
                             input logic [7:0] tx);
    send_item(OP_STATUS, code, rx, tx);
  endtask

  // Lowers the input valid and holds off until every predicted result has been checked.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_actions.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ADDRESS:   slave_addr    = data;
      REG_SEND_CNT:  send_cfg      = data[4:0];
      REG_RECV_CNT:  recv_cfg      = data[1:0];
      REG_REP_START: rep_start_cfg = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_transfer_regs(input logic [7:0] addr, input logic [7:0] send_n,
                                       input logic [7:0] recv_n, input logic [7:0] rep);
    write_reg(REG_ADDRESS, addr);
    write_reg(REG_SEND_CNT, send_n);
    write_reg(REG_RECV_CNT, recv_n);
    write_reg(REG_REP_START, rep);
    cfg_valid <= 1'b0;
    configs_used++;
  endtask

  task automatic send_noise_item();
    logic [7:0] code;
    code = $urandom_range(0, 1) ? 8'($urandom) : KNOWN_CODES[$urandom_range(0, 11)];
    send_item(($urandom_range(0, 9) == 0) ? OP_START : OP_STATUS, code, 8'($urandom),
              8'($urandom));
  endtask

  // A status item for a well-formed transfer, occasionally preceded by a stray item.
  task automatic send_flow_status(input logic [7:0] code);
    if ($urandom_range(0, 99) < 6) send_noise_item();
    send_status(code, 8'($urandom), 8'($urandom));
  endtask

  // One complete write phase and, when configured, the read phase after a repeated START.
  task automatic run_transfer();
    logic [4:0] sends_before;
    logic [1:0] recvs_before;
    send_item(OP_START, 8'($urandom), 8'($urandom), 8'($urandom));
    send_flow_status(ST_START);
    sends_before = send_left;
    send_flow_status(ST_ADDR_ACK);
    if (sends_before != 0) begin
      do begin
        sends_before = send_left;
        send_flow_status(ST_DATA_ACK);
      end while (sends_before != 0);
    end
    if (rep_start_cfg) begin
      send_flow_status(ST_REP_START);
      send_flow_status(ST_RD_ADDR_ACK);
      do begin
        recvs_before = recv_left;
        send_flow_status(ST_RD_DATA_ACK);
      end while (recvs_before != 0);
    end
    transfers_run++;
  endtask

  // Write then read from the accelerometer, with idle events and a start while busy.
  task automatic test_accel_write_read();
    program_transfer_regs(ACC_ADDRESS, 8'd2, 8'd3, 8'd1);
    send_status(ST_BUS_ERROR, 8'h00, 8'h00);
    send_status(ST_RD_DATA_ACK, 8'hFF, 8'hFF);
    send_item(OP_START, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_START, 8'h00, 8'h00, 8'h00);
    send_status(ST_START, 8'h00, 8'h00);
    send_status(ST_ADDR_ACK, 8'h00, 8'hFF);
    send_status(ST_DATA_ACK, 8'hFF, 8'h00);
    send_status(ST_DATA_ACK, 8'h00, 8'h00);
    send_status(ST_REP_START, 8'h00, 8'h00);
    send_status(ST_RD_ADDR_ACK, 8'h00, 8'h00);
    send_status(ST_RD_DATA_ACK, 8'hFF, 8'h00);
    send_status(ST_RD_DATA_ACK, 8'h00, 8'hFF);
    send_status(ST_RD_DATA_ACK, 8'h5A, 8'hA5);
    send_status(ST_RD_DATA_ACK, 8'hC3, 8'h3C);
    wait_for_results();
  endtask

  // Thermometer read with the overflow drop, then every remaining code and an unknown one.
  task automatic test_thermo_and_errors();
    program_transfer_regs(THERM_ADDRESS, 8'd0, 8'd3, 8'd0);
    send_item(OP_START, 8'h00, 8'h00, 8'h00);
    send_status(ST_START, 8'h00, 8'h00);
    send_status(ST_ADDR_ACK, 8'h00, 8'h77);
    send_status(ST_RD_DATA_ACK, 8'h11, 8'h00);
    send_status(ST_RD_DATA_ACK, 8'h22, 8'h00);
    send_status(ST_RD_DATA_ACK, 8'h33, 8'h00);
    send_status(ST_RD_DATA_ACK, 8'h44, 8'h00);
    send_status(ST_ADDR_NACK, 8'h00, 8'h00);
    send_status(ST_DATA_NACK, 8'h00, 8'h00);
    send_status(ST_ARB_LOST, 8'h00, 8'h00);
    send_status(ST_RD_ADDR_NAK, 8'h00, 8'h00);
    send_status(ST_RD_DATA_NAK, 8'h00, 8'h00);
    send_status(8'hFF, 8'hFF, 8'hFF);
    wait_for_results();
  endtask

  task automatic test_random_transfers();
    int          budget;
    int          phase;
    logic [7:0]  addr;
    logic [7:0]  send_n;
    logic [7:0]  recv_n;
    logic [7:0]  rep;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      // The first two phases pin the register extremes.
      if (phase == 0) begin
        addr = 8'hFF; send_n = 8'h1F; recv_n = 8'h03; rep = 8'h01;
      end else if (phase == 1) begin
        addr = 8'h00; send_n = 8'h00; recv_n = 8'h00; rep = 8'h00;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: addr = ACC_ADDRESS;
          3, 4, 5: addr = THERM_ADDRESS;
          6:       addr = ACC_ADDRESS | READ_BIT;
          default: addr = 8'($urandom);
        endcase
        send_n = 8'($urandom);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: send_n[4:0] = 5'($urandom_range(0, 4));
          7, 8:                send_n[4:0] = 5'($urandom_range(5, MAX_SEND));
          default:             send_n[4:0] = 5'($urandom_range(MAX_SEND + 1, 31));
        endcase
        recv_n = 8'($urandom);
        rep    = 8'($urandom);
      end
      program_transfer_regs(addr, send_n, recv_n, rep);
      steady = ($urandom_range(0, 5) == 0);
      budget = items_sent + $urandom_range(20, 80);
      while (items_sent < budget) begin
        if ($urandom_range(0, 9) < 8) begin
          run_transfer();
        end else begin
          repeat ($urandom_range(1, 5)) send_noise_item();
        end
        if ($urandom_range(0, 19) == 0) wait_for_results();
      end
      wait_for_results();
      steady = 1'b0;
      phase++;
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ADDRESS;
    cfg_data      = 8'h00;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = OP_START;
    slave_addr    = 8'h00;
    send_cfg      = 5'd0;
    recv_cfg      = 2'd0;
    rep_start_cfg = 1'b0;
    send_left     = 5'd0;
    recv_left     = 2'd0;
    xfer_busy     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_accel_write_read();
    test_thermo_and_errors();
    test_random_transfers();

    wait_for_results();
    repeat (10) @(negedge clk);
    $display("Ran %0d items in %0d register settings, %0d well-formed transfers,",
             items_sent, configs_used, transfers_run);
    $display("checked %0d results; %0d field mismatches.", results_seen, mismatches);
    if (mismatches == 0 && pending_actions.size() == 0) begin
      $display("smbus_master_transfer_sequencer test passed");
    end else begin
      $display("smbus_master_transfer_sequencer test failed");
    end
    $finish;
  end

endmodule

/* smbus_master_transfer_sequencer.f */
rtl/smts_pkg.sv
rtl/smbus_master_transfer_sequencer.sv
dv/tb.sv
